@@ hw/rtl/mwpo_pkg.sv @@
package mwpo_pkg;

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;

  localparam int PHASE_VALUE_W = 32;
  localparam int TUNING_W      = 32;
  localparam int SAMPLE_W      = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [2:0] {
    WAVE_SINE      = 3'd0,
    WAVE_SQUARE    = 3'd1,
    WAVE_SAW_UP    = 3'd2,
    WAVE_SAW_DOWN  = 3'd3,
    WAVE_TRIANGLE  = 3'd4
  } wave_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TUNING_WORD = 2'd0,
    CFG_WAVE_SELECT = 2'd1
  } cfg_index_e;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

  // stage-one result handed to the sample stage
  typedef struct packed {
    logic                       is_sine;
    logic                       neg;
    logic signed [SAMPLE_W-1:0] wave;
  } shape_t;

endpackage

@@ hw/rtl/mwpo_if.sv @@
interface mwpo_in_if
  import mwpo_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [PHASE_VALUE_W-1:0] phase_value;

  modport source (output valid, output func, output phase_value, input ready);
  modport sink   (input valid, input func, input phase_value, output ready);
endinterface

interface mwpo_out_if
  import mwpo_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mwpo_cfg_if
  import mwpo_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/mwpo_sine_rom.sv @@
module mwpo_sine_rom
  import mwpo_pkg::*;
#(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [SINE_ADDR_BITS:0] addr_i,
  output logic [SAMPLE_W-2:0]     data_o
);

  localparam int TabN = 1 << SINE_ADDR_BITS;

  typedef logic [SAMPLE_W-2:0] tab_t [TabN+1];

  // quarter-wave sine, round(32767*sin(pi/2*k/N)) via Q30 Taylor series
  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] scaled;
    for (int k = 0; k <= TabN; k++) begin
      x    = (64'(k) * 64'd1686629713) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      scaled = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      t[k]   = scaled[SAMPLE_W-2:0];
    end
    return t;
  endfunction

  localparam tab_t Tab = build_tab();

  logic [SAMPLE_W-2:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= Tab[addr_i];
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/mwpo_shaper.sv @@
module mwpo_shaper
  import mwpo_pkg::*;
#(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic [PHASE_BITS-1:0]   phase_i,
  input  wave_e                   wave_i,
  output shape_t                  shape_o,
  output logic [SINE_ADDR_BITS:0] addr_o
);

  localparam logic [SINE_ADDR_BITS:0] TabN = (SINE_ADDR_BITS+1)'(1) << SINE_ADDR_BITS;
  localparam logic signed [SAMPLE_W:0]   Half17 = (SAMPLE_W+1)'(32768);
  localparam logic signed [SAMPLE_W+1:0] Half18 = (SAMPLE_W+2)'(32768);

  function automatic logic signed [SAMPLE_W-1:0] sat_q15(logic signed [SAMPLE_W+1:0] v);
    if (v > 18'sd32767)       return 16'sh7fff;
    else if (v < -18'sd32768) return 16'sh8000;
    else                      return v[SAMPLE_W-1:0];
  endfunction

  logic [1:0]                  quad;
  logic [SINE_ADDR_BITS-1:0]   idx;
  logic [SAMPLE_W-1:0]         u;
  logic signed [SAMPLE_W:0]    d;
  logic signed [SAMPLE_W:0]    d_abs;
  logic signed [SAMPLE_W+1:0]  down_v;
  logic signed [SAMPLE_W+1:0]  tri_v;
  logic                        sq_hi;

  assign quad  = phase_i[PHASE_BITS-1 -: 2];
  assign idx   = phase_i[PHASE_BITS-3 -: SINE_ADDR_BITS];
  assign u     = phase_i[PHASE_BITS-1 -: SAMPLE_W];
  assign d     = $signed({1'b0, u}) - Half17;
  assign d_abs = d[SAMPLE_W] ? -d : d;
  assign down_v = -{d[SAMPLE_W], d};
  assign tri_v  = {d_abs, 1'b0} - Half18;
  // phase <= half turn
  assign sq_hi = !phase_i[PHASE_BITS-1] || (phase_i[PHASE_BITS-2:0] == '0);

  assign addr_o = quad[0] ? (TabN - {1'b0, idx}) : {1'b0, idx};

  always_comb begin
    shape_o.is_sine = 1'b0;
    shape_o.neg     = quad[1];
    shape_o.wave    = '0;
    case (wave_i)
      WAVE_SQUARE:   shape_o.wave = sq_hi ? 16'sh7fff : 16'sh0000;
      WAVE_SAW_UP:   shape_o.wave = {~u[SAMPLE_W-1], u[SAMPLE_W-2:0]};
      WAVE_SAW_DOWN: shape_o.wave = sat_q15(down_v);
      WAVE_TRIANGLE: shape_o.wave = sat_q15(tri_v);
      default:       shape_o.is_sine = 1'b1;
    endcase
  end

endmodule

@@ hw/rtl/multi_wave_phase_oscillator_core.sv @@
// channel  | dir | handshake     | payload
// in_i     | in  | valid/ready   | func, phase_value[31:0]
// out_o    | out | valid/ready   | sample[15:0] signed Q1.15
// cfg_i    | in  | valid/ready   | index[1:0], data[31:0]
//
// One item per cycle sustained while out_o is ready. A tick item's sample reaches out_o
// through the phase stage, the registered sine table read and the sample register.
// Load items update the phase at acceptance and enter no stage.
// Reset clears the phase, both registers and all stage valid bits.
// When out_o stalls, stages fill in turn; in_i.ready drops only when all are full.
module multi_wave_phase_oscillator_core
  import mwpo_pkg::*;
#(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwpo_in_if.sink     in_i,
  mwpo_out_if.source  out_o,
  mwpo_cfg_if.sink    cfg_i
);

  localparam int ExtW = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  logic [TUNING_W-1:0]   tuning_q;
  wave_e                 wave_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS-1:0] phase_d;

  logic                  v1_q, v2_q, v3_q;
  logic                  rdy1, rdy2, rdy3;
  logic [PHASE_BITS-1:0] ph1_q;
  shape_t                shape1, shape2_q;
  logic [SINE_ADDR_BITS:0] addr1;
  logic [SAMPLE_W-2:0]   rom_data;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] sample_d;

  logic [ExtW-1:0] pv_ext;
  logic [ExtW-1:0] tw_ext;
  logic            in_acc;
  logic            tick_acc;

  assign pv_ext   = ExtW'(in_i.phase_value);
  assign tw_ext   = ExtW'(tuning_q);
  assign in_acc   = in_i.valid && in_i.ready;
  assign tick_acc = in_acc && (func_e'(in_i.func) == FUNC_TICK);

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q <= '0;
      wave_q   <= WAVE_SINE;
    end else if (cfg_i.valid) begin
      case (cfg_index_e'(cfg_i.index))
        CFG_TUNING_WORD: tuning_q <= cfg_i.data[TUNING_W-1:0];
        CFG_WAVE_SELECT: wave_q   <= wave_e'(cfg_i.data[2:0]);
        default: ;
      endcase
    end
  end

  // phase accumulator
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      if (func_e'(in_i.func) == FUNC_LOAD) phase_d = pv_ext[PHASE_BITS-1:0];
      else                                 phase_d = phase_q + tw_ext[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= '0;
    else         phase_q <= phase_d;
  end

  // stage handshake
  assign rdy3       = !v3_q || out_o.ready;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= tick_acc;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && tick_acc) ph1_q <= phase_q;
    if (rdy2 && v1_q)     shape2_q <= shape1;
    if (rdy3 && v2_q)     sample_q <= sample_d;
  end

  mwpo_shaper #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_shaper (
    .phase_i (ph1_q),
    .wave_i  (wave_q),
    .shape_o (shape1),
    .addr_o  (addr1)
  );

  mwpo_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (rdy2 && v1_q),
    .addr_i (addr1),
    .data_o (rom_data)
  );

  always_comb begin
    if (shape2_q.is_sine) begin
      sample_d = shape2_q.neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
    end else begin
      sample_d = shape2_q.wave;
    end
  end

  assign out_o.valid  = v3_q;
  assign out_o.sample = sample_q;

  a_load_sets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.func == FUNC_LOAD) |=> phase_q == $past(pv_ext[PHASE_BITS-1:0]))
    else $error("load did not set phase");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> phase_q == $past(phase_q + tw_ext[PHASE_BITS-1:0]))
    else $error("tick did not advance phase");

  a_stall_holds_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> (v2_q && $stable(shape2_q)))
    else $error("stage two lost an item under stall");

  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free stage");

endmodule

@@ bench/multi_wave_phase_oscillator_core_test.sv @@
module multi_wave_phase_oscillator_core_test;
  import mwpo_pkg::*;

  localparam int PIPE_LAT        = 3;
  localparam int SINE_N          = 1 << SINE_ADDR_BITS_DEF;
  localparam int N_DIRECTED      = 32;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 63;
  localparam int HOLD_PHASE      = 2;
  localparam int HOLD_CYCLES     = 60;
  localparam int TIMEOUT_CYCLES  = 200_000;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1 << 30;

  // indexes past the register list
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
  // wave code past the named ones, decodes as sine
  localparam logic [2:0] WAVE_SPARE_TOP = 3'd7;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    logic [CFG_INDEX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]      data;
    func_e                      func;
    logic [PHASE_VALUE_W-1:0]   phase;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] sample;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mwpo_in_if  in_if();
  mwpo_out_if out_if();
  mwpo_cfg_if cfg_if();

  multi_wave_phase_oscillator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [15:0]                quarter_sine [0:SINE_N];
  logic [PHASE_VALUE_W-1:0]   osc_phase;
  logic [TUNING_W-1:0]        osc_tuning;
  logic [2:0]                 osc_wave;
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int                         mismatches;
  bit                         no_gaps;
  bit                         long_hold_req;
  step_t                      directed [N_DIRECTED];
  logic [PHASE_VALUE_W-1:0]   corner_phase [4] = '{32'h0, 32'h4000_0000, 32'h8000_0000,
                                                   32'hFFFF_FFFF};

  function automatic void build_quarter_sine();
    longint unsigned x, x2, term;
    longint          sum;
    for (int k = 0; k <= SINE_N; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS_DEF;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      quarter_sine[k] = 16'((longint'(sum) * 32767 + (64'sd1 << 29)) >>> 30);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] wave_value(logic [PHASE_VALUE_W-1:0] ph);
    int         u, d, v;
    logic [9:0] idx;
    u   = int'(ph[31:16]);
    idx = ph[29:20];
    case (osc_wave)
      WAVE_SQUARE:   v = (ph <= 32'h8000_0000) ? 32767 : 0;
      WAVE_SAW_UP:   v = u - 32768;
      WAVE_SAW_DOWN: v = 32768 - u;
      WAVE_TRIANGLE: begin
        d = (u >= 32768) ? u - 32768 : 32768 - u;
        v = 2 * d - 32768;
      end
      default: begin
        v = ph[30] ? int'(quarter_sine[SINE_N - int'(idx)]) : int'(quarter_sine[idx]);
        if (ph[31]) v = -v;
      end
    endcase
    if (v > 32767) v = 32767;
    return SAMPLE_W'(v);
  endfunction

  function automatic step_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    return '{ROW_CFG, idx, val, FUNC_TICK, '0, 1'b0, '0};
  endfunction

  function automatic step_t load_row(logic [PHASE_VALUE_W-1:0] pv);
    return '{ROW_ITEM, CFG_TUNING_WORD, '0, FUNC_LOAD, pv, 1'b0, '0};
  endfunction

  function automatic step_t tick_row(bit typed, logic signed [SAMPLE_W-1:0] val);
    return '{ROW_ITEM, CFG_TUNING_WORD, '0, FUNC_TICK, PHASE_VALUE_W'($urandom), typed, val};
  endfunction

  task automatic send_item(func_e f, logic [PHASE_VALUE_W-1:0] pv, bit typed = 1'b0,
                           logic signed [SAMPLE_W-1:0] typed_val = '0);
    logic signed [SAMPLE_W-1:0] s;
    in_if.valid       <= 1'b1;
    in_if.func        <= f;
    in_if.phase_value <= pv;
    do @(posedge clk_i); while (!in_if.ready);
    if (f == FUNC_LOAD) begin
      osc_phase = pv;
    end else begin
      s         = wave_value(osc_phase);
      osc_phase = osc_phase + osc_tuning;
      expected_samples.push_back(typed ? typed_val : s);
    end
    @(negedge clk_i);
  endtask

  task automatic idle_in(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_TUNING_WORD: osc_tuning = val;
      CFG_WAVE_SELECT: osc_wave = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // wait for every sample, then let any trailing load settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 1) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: expected none, got %0d", out_if.sample);
        mismatches++;
      end else if (expected_samples[0] !== out_if.sample) begin
        $error("sample: expected %0d, got %0d", expected_samples[0], out_if.sample);
        mismatches++;
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("multi_wave_phase_oscillator_core_test: errors");
    $finish;
  end

  initial begin
    logic [TUNING_W-1:0] tw;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_TICK;
    in_if.phase_value = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_TUNING_WORD;
    cfg_if.data       = '0;
    mismatches        = 0;
    no_gaps           = 1'b0;
    long_hold_req     = 1'b0;
    osc_phase         = '0;
    osc_tuning        = '0;
    osc_wave          = WAVE_SINE;
    build_quarter_sine();

    directed = '{
      tick_row(1'b1, 16'sd0),
      load_row(32'h4000_0000), tick_row(1'b1, 16'sd32767),
      load_row(32'hC000_0000), tick_row(1'b1, -16'sd32767),
      cfg_row(CFG_WAVE_SELECT, 32'(WAVE_SQUARE)),
      load_row(32'h8000_0000), tick_row(1'b1, 16'sd32767),
      load_row(32'h8000_0001), tick_row(1'b1, 16'sd0),
      cfg_row(CFG_WAVE_SELECT, 32'(WAVE_SAW_UP)),
      load_row(32'h0), tick_row(1'b1, -16'sd32768),
      load_row(32'hFFFF_FFFF), tick_row(1'b1, 16'sd32767),
      cfg_row(CFG_WAVE_SELECT, 32'(WAVE_SAW_DOWN)),
      load_row(32'h0), tick_row(1'b1, 16'sd32767),
      load_row(32'hFFFF_0000), tick_row(1'b1, -16'sd32767),
      cfg_row(CFG_WAVE_SELECT, 32'(WAVE_TRIANGLE)),
      load_row(32'h0), tick_row(1'b1, 16'sd32767),
      load_row(32'h8000_0000), tick_row(1'b1, -16'sd32768),
      cfg_row(CFG_SPARE_B, 32'hFFFF_FFFF), tick_row(1'b1, -16'sd32768),
      cfg_row(CFG_WAVE_SELECT, {29'h1FFF_FFFF, WAVE_SPARE_TOP}), tick_row(1'b1, 16'sd0),
      cfg_row(CFG_TUNING_WORD, 32'hFFFF_FFFF), tick_row(1'b1, 16'sd0),
      tick_row(1'b0, '0)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed[i].index, directed[i].data);
        cfg_if.valid <= 1'b0;
      end else begin
        send_item(directed[i].func, directed[i].phase, directed[i].typed, directed[i].sample);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      no_gaps = (ph == N_PHASES - 1);
      case ($urandom_range(0, 5))
        0: tw = '0;
        1: tw = '1;
        2: tw = 32'h1;
        3: tw = 32'h8000_0000;
        default: tw = TUNING_W'($urandom);
      endcase
      write_reg(CFG_TUNING_WORD, tw);
      write_reg(CFG_WAVE_SELECT, (32'($urandom) & ~32'h7) | 32'(ph % 8));
      if (ph % 3 == 1) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
      cfg_if.valid <= 1'b0;
      if (ph == HOLD_PHASE) long_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!no_gaps && ph != HOLD_PHASE && $urandom_range(0, 5) == 0)
          idle_in($urandom_range(1, 7));
        if ($urandom_range(0, 4) == 0)
          send_item(FUNC_LOAD, ($urandom_range(0, 3) == 0) ? corner_phase[$urandom_range(0, 3)]
                                                          : PHASE_VALUE_W'($urandom));
        else
          send_item(FUNC_TICK, PHASE_VALUE_W'($urandom));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("multi_wave_phase_oscillator_core_test: clean");
    end else begin
      $display("multi_wave_phase_oscillator_core_test: errors");
    end
    $finish;
  end

endmodule
